[design/sdaf_pkg.sv]
// shared constants, types and a sizing function for the decimal text formatter
`default_nettype none

package sdaf_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int Radix = 10;

   // number of decimal digits in the largest magnitude, 2^(VALUE_WIDTH-1)
   function automatic int digits_for_width(input int width);
      longint unsigned v;
      int n;
      begin
         v = longint'(1) << (width - 1);
         n = 1;
         v = v / Radix;
         while (v != 0) begin
            n = n + 1;
            v = v / Radix;
         end
         return n;
      end
   endfunction

   localparam int DIGIT_COUNT = digits_for_width(VALUE_WIDTH);
   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int CHAR_WIDTH = 6;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = CHAR_WIDTH'(57);
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef logic [BCD_WIDTH-1:0] bcd_type;

endpackage

`default_nettype wire

[design/sdaf_dabble_step.sv]
// one shift-and-add-3 step of binary to packed bcd conversion
`default_nettype none

module sdaf_dabble_step
   import sdaf_pkg::*;
(
   input  var bcd_type bcd_cur,
   input  wire         bit_in,
   output bcd_type     bcd_next
);

   bcd_type adjusted;

   // each digit of 5 or more gets 3 added so the doubling carries in decimal
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_cur[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_cur[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_cur[4*i +: 4];
         end
      end
   end

   assign bcd_next = {adjusted[BCD_WIDTH-2:0], bit_in};

endmodule

`default_nettype wire

[design/signed_decimal_ascii_formatter.sv]
// top level: sequencer that renders a signed value as ascii decimal characters
//
// Usage: drive req_value and raise start; the item is taken at a rising edge where
// start is high and busy is low. busy then stays high until all characters of that
// value have been produced. Characters come out most significant first on
// rsp_character, each valid for exactly one cycle while rsp_strobe is high;
// rsp_last marks the final character. A negative value first gives '-', leading
// zeros are dropped, and zero gives the single character '0'.
// Timing: the magnitude runs through a shared shift-and-add-3 unit one bit a cycle,
// then a digit sweep skips leading zeros and emits one character a cycle. The '-'
// appears the cycle after accept. A new value is taken only once busy is low again,
// after all characters of the last one. The last character is on the outputs in the
// first cycle busy is low again.
// The receiver cannot stall; characters are never held back or repeated.
// Reset (synchronous, active high) returns the sequencer to idle and clears the
// strobe; no value is kept between items.
`default_nettype none

module signed_decimal_ascii_formatter
   import sdaf_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [VALUE_WIDTH-1:0] req_value,
   output logic                         rsp_strobe,
   output logic       [CHAR_WIDTH-1:0]  rsp_character,
   output logic                         rsp_last
);

   state_type state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   bcd_type bcd_ff, bcd_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic strobe_ff, strobe_in;
   logic [CHAR_WIDTH-1:0] char_ff, char_in;
   logic last_ff, last_in;

   bcd_type bcd_step;
   logic [VALUE_WIDTH-1:0] value_u;
   logic [3:0] top_digit;

   sdaf_dabble_step u_step (
      .bcd_cur  (bcd_ff),
      .bit_in   (mag_ff[VALUE_WIDTH-1]),
      .bcd_next (bcd_step)
   );

   assign value_u = VALUE_WIDTH'(unsigned'(req_value));
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      count_ff <= count_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      count_in = count_ff;
      strobe_in = 1'b0;
      char_in = char_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // two's complement magnitude, most negative value wraps to 2^(w-1)
               if (req_value[VALUE_WIDTH-1]) begin
                  mag_in = ~value_u + VALUE_WIDTH'(1);
                  strobe_in = 1'b1;
                  char_in = ASCII_MINUS;
                  last_in = 1'b0;
               end else begin
                  mag_in = value_u;
               end
               bcd_in = '0;
               count_in = COUNT_WIDTH'(VALUE_WIDTH);
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            count_in = count_ff - COUNT_WIDTH'(1);
            if (count_ff == COUNT_WIDTH'(1)) begin
               count_in = COUNT_WIDTH'(DIGIT_COUNT);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros but always keep the ones digit
            if (top_digit == 4'd0 && count_ff != COUNT_WIDTH'(1)) begin
               bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               count_in = count_ff - COUNT_WIDTH'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            char_in = ASCII_ZERO + CHAR_WIDTH'(top_digit);
            last_in = (count_ff == COUNT_WIDTH'(1));
            bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
            count_in = count_ff - COUNT_WIDTH'(1);
            if (count_ff == COUNT_WIDTH'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_character == ASCII_MINUS ||
                      (rsp_character >= ASCII_ZERO && rsp_character <= ASCII_NINE)))
      else $error("character out of range");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_character == ASCII_MINUS) |-> !rsp_last)
      else $error("minus sign marked as last character");

   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      (!busy && rsp_strobe) |-> rsp_last)
      else $error("non-final character shown while idle");

endmodule

`default_nettype wire

[tb/decimal_text_checker.sv]
// checker: predicts the ascii decimal text of each accepted value and compares results
`default_nettype none

module decimal_text_checker
   import sdaf_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire                          busy,
   input  wire signed [VALUE_WIDTH-1:0] req_value,
   input  wire                          rsp_strobe,
   input  wire        [CHAR_WIDTH-1:0]  rsp_character,
   input  wire                          rsp_last,
   output int                           mismatch_count,
   output int                           chars_outstanding
);

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code;
      logic                  is_last;
   } text_char_type;

   text_char_type expected_chars[$];

   // appends the expected characters of one value, most significant first
   function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] raw);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [3:0]             digit_buf [0:DIGIT_COUNT-1];
      int                     ndigits;
      text_char_type          ch;
      begin
         ndigits = 0;
         // unsigned negate, so the most negative value keeps its magnitude
         magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
         if (raw[VALUE_WIDTH-1]) begin
            ch.code = ASCII_MINUS;
            ch.is_last = 1'b0;
            expected_chars.push_back(ch);
         end
         do begin
            digit_buf[ndigits] = 4'(magnitude % VALUE_WIDTH'(Radix));
            magnitude = magnitude / VALUE_WIDTH'(Radix);
            ndigits++;
         end while (magnitude != 0 && ndigits < DIGIT_COUNT);
         for (int k = ndigits - 1; k >= 0; k--) begin
            ch.code = ASCII_ZERO + CHAR_WIDTH'(digit_buf[k]);
            ch.is_last = (k == 0);
            expected_chars.push_back(ch);
         end
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      int errs;
      errs = 0;
      if (reset) begin
         mismatch_count <= 0;
         chars_outstanding <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character %0d (last %0d) with no item pending",
                      rsp_character, rsp_last);
               errs++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.code) begin
                  $error("character: expected %0d, got %0d", want.code, rsp_character);
                  errs++;
               end
               if (rsp_last !== want.is_last) begin
                  $error("last: expected %0d, got %0d", want.is_last, rsp_last);
                  errs++;
               end
            end
         end
         if (start && !busy)
            queue_decimal_text(req_value);
         mismatch_count <= mismatch_count + errs;
         chars_outstanding <= expected_chars.size();
      end
   end

endmodule

`default_nettype wire

[tb/tb_signed_decimal_ascii_formatter.sv]
// testbench top: drives values into the decimal text formatter and reports the verdict
`default_nettype none

module tb_signed_decimal_ascii_formatter;
   import sdaf_pkg::*;

   localparam int RandomItems = 236;
   localparam int BlockItems = 20;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles = 60;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_strobe;
   logic        [CHAR_WIDTH-1:0]  rsp_character;
   logic                          rsp_last;
   int                            mismatch_count;
   int                            chars_outstanding;
   int                            idle_cycles;

   signed_decimal_ascii_formatter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   decimal_text_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_character     (rsp_character),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // counts cycles where neither an item nor a character moves, and ends the run with an error verdict at WatchdogLimit
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("tb_signed_decimal_ascii_formatter: done, errors");
            $finish;
         end
      end
   end

   // start stays high across back-to-back items, lowered only before a gap
   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v, input int max_gap);
      int gap;
      begin
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            start <= 1'b0;
            req_value <= $urandom;
            repeat (gap) @(posedge clock);
         end
         start <= 1'b1;
         req_value <= v;
         do @(posedge clock); while (busy);
      end
   endtask

   // mix of full-range values and values of a random digit count and sign
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      int unsigned ndigits;
      int unsigned lo;
      int unsigned hi;
      int unsigned mag;
      begin
         if ($urandom_range(0, 9) < 4)
            return $urandom;
         ndigits = $urandom_range(1, 10);
         lo = 1;
         for (int i = 1; i < ndigits; i++)
            lo = lo * 10;
         hi = (ndigits == 10) ? 32'h7fff_ffff : lo * 10 - 1;
         if (ndigits == 1)
            lo = 0;
         mag = $urandom_range(lo, hi);
         return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      end
   endfunction

   int directed_values[] = '{
      0, 1, -1, 5, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
      999999999, -999999999, 1000000000, -1000000000, 1234567890, -1234567890,
      32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0000, 32'sh5555_5555, 32'shaaaa_aaaa
   };

   initial begin
      int max_gap;
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i])
         send_value(directed_values[i], (i % 3 == 0) ? 19 : 0);

      for (int n = 0; n < RandomItems; n++) begin
         if (n % BlockItems == 0)
            max_gap = $urandom_range(0, 2) == 0 ? 0 : 19;
         send_value(random_value(), max_gap);
      end
      start <= 1'b0;

      @(posedge clock);
      while (chars_outstanding != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_signed_decimal_ascii_formatter: done, clean");
      else
         $display("tb_signed_decimal_ascii_formatter: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
